// ----- hw/rtl/ttu_pkg.sv -----
// ttu_pkg: shared types and constants for the twiddled texel unpack unit.
// Request/result structs, configuration register map, pixel format codes.
// No dependencies.
`timescale 1ns / 1ps

package ttu_pkg;

  localparam int MAX_SIDE_LOG2_DEF = 10;
  localparam int TEXEL_W = 16;
  localparam int POS_W   = 20;
  localparam int CHAN_W  = 8;
  localparam int SIDE_W  = 4;
  localparam int FMT_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TWIDDLED    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FMT   = 2'd3;

  typedef enum logic [FMT_W-1:0] {
    FMT_ARGB1555 = 2'd0,
    FMT_RGB565   = 2'd1,
    FMT_ARGB4444 = 2'd2,
    FMT_YUV422   = 2'd3
  } ttu_fmt_t;

  typedef struct packed {
    logic [SIDE_W-1:0] width_log2;
    logic [SIDE_W-1:0] height_log2;
    logic              twiddled_mode;
    ttu_fmt_t          pixel_format;
  } ttu_cfg_t;

  typedef struct packed {
    logic [TEXEL_W-1:0] texel;
    logic [POS_W-1:0]   stored_position;
  } ttu_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } ttu_rgba_t;

  typedef struct packed {
    logic [POS_W-1:0]  dest_index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } ttu_res_t;

endpackage

// ----- hw/rtl/ttu_cfg_regs.sv -----
// ttu_cfg_regs: configuration register file, write-only.
// Depends on ttu_pkg for the register map and config struct.
`timescale 1ns / 1ps

module ttu_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ttu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output ttu_pkg::ttu_cfg_t                cfg
);

  ttu_pkg::ttu_cfg_t cfg_r;
  ttu_pkg::ttu_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ttu_pkg::REG_WIDTH_LOG2:  cfg_nxt.width_log2    = cfg_wdata[ttu_pkg::SIDE_W-1:0];
        ttu_pkg::REG_HEIGHT_LOG2: cfg_nxt.height_log2   = cfg_wdata[ttu_pkg::SIDE_W-1:0];
        ttu_pkg::REG_TWIDDLED:    cfg_nxt.twiddled_mode = cfg_wdata[0];
        ttu_pkg::REG_PIXEL_FMT:
          cfg_nxt.pixel_format = ttu_pkg::ttu_fmt_t'(cfg_wdata[ttu_pkg::FMT_W-1:0]);
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_log2    <= '0;
      cfg_r.height_log2   <= '0;
      cfg_r.twiddled_mode <= 1'b1;
      cfg_r.pixel_format  <= ttu_pkg::FMT_ARGB1555;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/ttu_untwiddle.sv -----
// ttu_untwiddle: Morton-order position to raster index, per-bit muxing.
// Depends on ttu_pkg for field widths.
`timescale 1ns / 1ps

module ttu_untwiddle #(
  parameter int MAX_SIDE_LOG2 = ttu_pkg::MAX_SIDE_LOG2_DEF
) (
  input  logic [ttu_pkg::SIDE_W-1:0] width_log2,
  input  logic [ttu_pkg::SIDE_W-1:0] height_log2,
  input  logic [ttu_pkg::POS_W-1:0]  pos,
  output logic [ttu_pkg::POS_W-1:0]  dest
);

  localparam int WIDE  = (2 * MAX_SIDE_LOG2 > ttu_pkg::POS_W) ? 2 * MAX_SIDE_LOG2
                                                              : ttu_pkg::POS_W;
  localparam int IDX_W = $clog2(WIDE);
  localparam logic [ttu_pkg::SIDE_W-1:0] SIDE_MAX = ttu_pkg::SIDE_W'(MAX_SIDE_LOG2);

  logic [ttu_pkg::SIDE_W-1:0] wl_sat;
  logic [ttu_pkg::SIDE_W-1:0] hl_sat;
  logic [WIDE-1:0]            pos_ext;
  logic [MAX_SIDE_LOG2-1:0]   row;
  logic [MAX_SIDE_LOG2-1:0]   col;
  logic [WIDE-1:0]            wide;

  assign wl_sat  = (width_log2 > SIDE_MAX) ? SIDE_MAX : width_log2;
  assign hl_sat  = (height_log2 > SIDE_MAX) ? SIDE_MAX : height_log2;
  assign pos_ext = WIDE'(pos);

  // Row bit i sits at i + min(i, wl); column bit i at i + min(i + 1, hl).
  always_comb begin
    row = '0;
    col = '0;
    for (int i = 0; i < MAX_SIDE_LOG2; i++) begin
      if (i < int'(hl_sat)) begin
        row[i] = pos_ext[IDX_W'(i + ((i < int'(wl_sat)) ? i : int'(wl_sat)))];
      end
      if (i < int'(wl_sat)) begin
        col[i] = pos_ext[IDX_W'(i + ((i + 1 < int'(hl_sat)) ? i + 1 : int'(hl_sat)))];
      end
    end
  end

  assign wide = (WIDE'(row) << wl_sat) | WIDE'(col);
  assign dest = wide[ttu_pkg::POS_W-1:0];

endmodule

// ----- hw/rtl/ttu_expand.sv -----
// ttu_expand: 16-bit packed texel to 8-bit RGBA channels.
// Depends on ttu_pkg for format codes and the channel struct.
`timescale 1ns / 1ps

module ttu_expand (
  input  ttu_pkg::ttu_fmt_t               fmt,
  input  logic [ttu_pkg::TEXEL_W-1:0]     texel,
  output ttu_pkg::ttu_rgba_t              rgba
);

  always_comb begin
    unique case (fmt)
      ttu_pkg::FMT_ARGB1555: begin
        rgba.alpha = {8{texel[15]}};
        rgba.red   = {texel[14:10], 3'b000};
        rgba.green = {texel[9:5], 3'b000};
        rgba.blue  = {texel[4:0], 3'b000};
      end
      ttu_pkg::FMT_RGB565: begin
        rgba.alpha = 8'hFF;
        rgba.red   = {texel[15:11], 3'b000};
        rgba.green = {texel[10:5], 2'b00};
        rgba.blue  = {texel[4:0], 3'b000};
      end
      ttu_pkg::FMT_ARGB4444: begin
        rgba.alpha = {texel[15:12], 4'h0};
        rgba.red   = {texel[11:8], 4'h0};
        rgba.green = {texel[7:4], 4'h0};
        rgba.blue  = {texel[3:0], 4'h0};
      end
      default: begin
        rgba.alpha = 8'hFF;
        rgba.red   = 8'hFF;
        rgba.green = 8'hFF;
        rgba.blue  = 8'hFF;
      end
    endcase
  end

endmodule

// ----- hw/rtl/twiddled_texel_unpack_unit.sv -----
// twiddled_texel_unpack_unit: top level of the texel unpacker.
// Depends on ttu_pkg, ttu_cfg_regs, ttu_untwiddle, ttu_expand.
`timescale 1ns / 1ps
//
// Usage:
//   Request channel: drive in_req (texel, stored_position) and raise start.
//   A request is taken at each rising edge with start high and busy low.
//   busy is low outside reset once busy_r has cleared after it, so one
//   request per cycle is taken while start is high: throughput is one texel per clock.
//   Result channel: out_valid is high for exactly one cycle with out_res
//   (dest_index, red, green, blue, alpha). A taken request passes through the
//   request register and then the result register before it shows on out_res.
//   The latency is set by the request register and the result register;
//   untwiddle and channel expansion are short logic between them.
//   The receiver cannot stall; results are never held.
//   Configuration: cfg_we/cfg_index/cfg_wdata write one register per edge;
//   the user must write only while no request is in flight; the block does not enforce this.
//   Reset (rst_n low, synchronous): registers return to width 1, height 1,
//   twiddled mode, ARGB1555; in-flight requests are dropped; busy is high
//   during reset and for the first cycle after it.

module twiddled_texel_unpack_unit #(
  parameter int MAX_SIDE_LOG2 = ttu_pkg::MAX_SIDE_LOG2_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  ttu_pkg::ttu_req_t               in_req,
  output logic                            out_valid,
  output ttu_pkg::ttu_res_t               out_res,
  input  logic                            cfg_we,
  input  logic [ttu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttu_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ttu_pkg::ttu_cfg_t          cfg;
  ttu_pkg::ttu_req_t          req_r;
  logic                       req_valid_r;
  logic                       busy_r;
  ttu_pkg::ttu_res_t          res_r;
  ttu_pkg::ttu_res_t          res_nxt;
  logic                       out_valid_r;
  logic [ttu_pkg::POS_W-1:0]  untw_dest;
  ttu_pkg::ttu_rgba_t         rgba;
  logic                       take;

  ttu_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ttu_untwiddle #(
    .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
  ) u_untw (
    .width_log2  (cfg.width_log2),
    .height_log2 (cfg.height_log2),
    .pos         (req_r.stored_position),
    .dest        (untw_dest)
  );

  ttu_expand u_exp (
    .fmt   (cfg.pixel_format),
    .texel (req_r.texel),
    .rgba  (rgba)
  );

  assign busy = busy_r | ~rst_n;
  assign take = start & ~busy;

  always_comb begin
    res_nxt.dest_index = cfg.twiddled_mode ? untw_dest : req_r.stored_position;
    res_nxt.red        = rgba.red;
    res_nxt.green      = rgba.green;
    res_nxt.blue       = rgba.blue;
    res_nxt.alpha      = rgba.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      req_valid_r <= take;
      out_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= in_req;
    end
    if (req_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// ----- hw/rtl/ttu_checker.sv -----
// ttu_checker: port-level assertions for twiddled_texel_unpack_unit.
// Depends on the top level's ports; bound to it at the end of this file.
`timescale 1ns / 1ps

module ttu_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_busy_in_reset: assert property (@(posedge clk) !rst_n |-> busy)
    else $error("busy low during reset");

  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("request did not produce a result two cycles later");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result strobe without a matching request");

endmodule

bind twiddled_texel_unpack_unit ttu_checker u_ttu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
